/* sv/parent_grouped_key_table_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef PARENT_GROUPED_KEY_TABLE_TOP_ASSERT_SVH
`define PARENT_GROUPED_KEY_TABLE_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PGKT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PGKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/pgkt_pkg.sv */
`timescale 1ns / 1ps
package pgkt_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_DEL_LEAF = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_NO_PARENT = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_HAS_CHILD = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input beat, reset scan pointer
    logic scan_step;  // evaluate current slot for the scan
    logic ins_init;   // load the carry from slot pos
    logic ins_step;   // one carry step
    logic ins_final;  // write the new entry at pos
    logic del_step;   // one compaction step
    logic del_final;  // clear the final gap
    logic clr_step;   // clear one slot after reset
  } pgkt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic ins_done;
    logic del_done;
    logic clr_done;
    logic [2:0] verdict;
    logic go_insert;
    logic go_delete;
  } pgkt_sts_t;
endpackage

/* sv/pgkt_if.sv */
`timescale 1ns / 1ps
interface pgkt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] key;
  logic [31:0] parent_key;
  logic [31:0] info;
  modport source (output valid, op, key, parent_key, info, input ready);
  modport sink (input valid, op, key, parent_key, info, output ready);
endinterface

interface pgkt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] info_out;
  modport source (output valid, status, info_out, input ready);
  modport sink (input valid, status, info_out, output ready);
endinterface

/* sv/parent_grouped_key_table_top.sv */
`timescale 1ns / 1ps
// Parent-grouped key table of TABLE_DEPTH entries (key, parent, info).
// Input channel in_*: one beat carries op, key, parent_key and info.
// Result channel out_*: one beat per input beat with status and info_out.
// cfg_we/cfg_wdata write meta_key, a parent accepted without being stored.
// One operation is handled at a time: in_ready is high only when idle.
// Each operation scans up to TABLE_DEPTH slots at one slot a cycle through
// the read port of the table memory, then for insert or delete makes a
// second pass over the slots after the touched position.
// After reset a clearing pass writes every slot to zero before the first
// beat is taken; meta_key resets to zero.
// The result is held until out_ready; the block takes no new beat before.
module parent_grouped_key_table_top
  import pgkt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pgkt_in_if.sink     in_ch,
  pgkt_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  logic [31:0] meta_key_r;
  pgkt_cmd_t   cmd;
  pgkt_sts_t   sts;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) meta_key_r <= '0;
    else if (cfg_we) meta_key_r <= cfg_wdata;
  end

  pgkt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  pgkt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst_n,
    .in_op(in_ch.op), .in_key(in_ch.key),
    .in_parent_key(in_ch.parent_key), .in_info(in_ch.info),
    .meta_key(meta_key_r), .cmd, .sts,
    .status(out_ch.status), .info_out(out_ch.info_out)
  );
endmodule

/* sv/pgkt_ctrl.sv */
`timescale 1ns / 1ps
module pgkt_ctrl
  import pgkt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pgkt_sts_t sts,
  output pgkt_cmd_t cmd
);
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_INS   = 8'b0001_0000,
    S_DEL   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   del_r, del_nxt;

  // Next-state logic and command decode.
  always_comb begin
    state_nxt = state_r;
    del_nxt = del_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.go_insert) begin
          cmd.ins_init = 1'b1;
          state_nxt = S_INS;
        end else if (sts.go_delete) begin
          state_nxt = S_DEL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (sts.ins_done) begin
          del_nxt = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_DEL: begin
        cmd.del_step = 1'b1;
        if (sts.del_done) begin
          del_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.ins_final = !del_r;
        cmd.del_final = del_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      del_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      del_r <= del_nxt;
    end
  end
endmodule

/* sv/pgkt_dp.sv */
`timescale 1ns / 1ps
module pgkt_dp
  import pgkt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_key,
  input  logic [31:0] in_parent_key,
  input  logic [31:0] in_info,
  input  logic [31:0] meta_key,
  input  pgkt_cmd_t   cmd,
  output pgkt_sts_t   sts,
  output logic [2:0]  status,
  output logic [31:0] info_out
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Table memory: one word of key, parent and info per slot.
  logic [95:0] mem [TABLE_DEPTH];
  logic [95:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [95:0]   wr_data;

  logic [1:0]  op_r;
  logic [31:0] key_r, par_r, info_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt, hit_r, hit_nxt;
  logic          found_r, found_nxt, child_r, child_nxt, par_ok_r, par_ok_nxt;
  logic          full_r, full_nxt;
  logic [31:0]   finfo_r, finfo_nxt;
  logic [95:0]   carry_r, carry_nxt;
  logic [CW-1:0] gap_r, gap_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [31:0]   info_out_r, info_out_nxt;
  logic          scan_done, ins_done, del_done;
  logic [31:0]   rk, rp;
  logic          occ;
  logic          stop_early;

  // Insert must see every occupied slot for the full and parent tests, and
  // conditional delete for the child test, so only delete and search stop
  // the scan at the hit.
  assign stop_early = (op_r == OP_DELETE) || (op_r == OP_SEARCH);

  // Synchronous read, registered.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign rk = rd_data[95:64];
  assign rp = rd_data[63:32];
  assign occ = (rk != 32'd0);

  // The read address runs one ahead of the slot being evaluated.
  always_comb begin
    rd_addr = idx_nxt[AW-1:0];
    if (idx_nxt >= DEPTH_C) rd_addr = '0;
  end

  // Sequencing of scan, carry and compaction passes.
  always_comb begin
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    hit_nxt = hit_r;
    found_nxt = found_r;
    child_nxt = child_r;
    par_ok_nxt = par_ok_r;
    full_nxt = full_r;
    finfo_nxt = finfo_r;
    carry_nxt = carry_r;
    gap_nxt = gap_r;
    rd_ok_nxt = 1'b0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    scan_done = 1'b0;
    ins_done = 1'b0;
    del_done = 1'b0;
    status_nxt = status_r;
    info_out_nxt = info_out_r;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
      wr_addr = idx_r[AW-1:0];
      idx_nxt = idx_r + CW'(1);
    end
    if (cmd.load) begin
      idx_nxt = '0;
      pos_nxt = '0;
      found_nxt = 1'b0;
      child_nxt = 1'b0;
      full_nxt = 1'b0;
      par_ok_nxt = (in_parent_key == 32'd0) || (in_parent_key == meta_key);
      rd_ok_nxt = 1'b1;
    end
    // Scan: one slot a cycle until the first empty slot or the end, or past the hit for delete and search.
    if (cmd.scan_step) begin
      if (!rd_ok_r) begin
        rd_ok_nxt = 1'b1;
      end else if (!occ || (found_r && stop_early)) begin
        scan_done = 1'b1;
      end else begin
        if (rk == key_r) begin
          found_nxt = 1'b1;
          hit_nxt = idx_r;
          finfo_nxt = rd_data[31:0];
        end
        if (rp == key_r) child_nxt = 1'b1;
        if (rp <= par_r) pos_nxt = idx_r + CW'(1);
        if (rk == par_r) par_ok_nxt = 1'b1;
        if (idx_r == DEPTH_C - CW'(1)) begin
          full_nxt = 1'b1;
          scan_done = 1'b1;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_ok_nxt = 1'b1;
        end
      end
    end
    if (cmd.ins_init) begin
      idx_nxt = pos_r;
      rd_ok_nxt = 1'b1;
    end
    // Insert carry: loads head at pos, then walks slots past it.
    if (cmd.ins_step) begin
      if (!rd_ok_r) begin
        rd_ok_nxt = 1'b1;
      end else if (idx_r == pos_r) begin
        carry_nxt = rd_data;
        if (idx_r == DEPTH_C - CW'(1)) ins_done = 1'b1;
        else begin
          idx_nxt = idx_r + CW'(1);
          rd_ok_nxt = 1'b1;
        end
      end else begin
        if (!(occ && rp == carry_r[63:32])) begin
          wr_en = 1'b1;
          wr_addr = idx_r[AW-1:0];
          wr_data = carry_r;
          carry_nxt = rd_data;
          // Stop early once an empty slot has taken the carry.
          if (!occ) ins_done = 1'b1;
        end
        if (!ins_done) begin
          if (idx_r == DEPTH_C - CW'(1)) ins_done = 1'b1;
          else begin
            idx_nxt = idx_r + CW'(1);
            rd_ok_nxt = 1'b1;
          end
        end
      end
    end
    // Delete: walk past the gap; at each group end move its last entry.
    if (cmd.del_step) begin
      if (!rd_ok_r) begin
        rd_ok_nxt = 1'b1;
      end else if (idx_r == gap_r) begin
        if (idx_r == DEPTH_C - CW'(1)) del_done = 1'b1;
        else begin
          idx_nxt = idx_r + CW'(1);
          rd_ok_nxt = 1'b1;
        end
      end else if (idx_r == gap_r + CW'(1)) begin
        if (!occ) del_done = 1'b1;
        else begin
          carry_nxt = rd_data;
          if (idx_r == DEPTH_C - CW'(1)) begin
            wr_en = 1'b1;
            wr_addr = gap_r[AW-1:0];
            wr_data = rd_data;
            gap_nxt = idx_r;
            del_done = 1'b1;
          end else begin
            idx_nxt = idx_r + CW'(1);
            rd_ok_nxt = 1'b1;
          end
        end
      end else begin
        if (occ && rp == carry_r[63:32]) begin
          carry_nxt = rd_data;
          if (idx_r == DEPTH_C - CW'(1)) begin
            wr_en = 1'b1;
            wr_addr = gap_r[AW-1:0];
            wr_data = rd_data;
            gap_nxt = idx_r;
            del_done = 1'b1;
          end else begin
            idx_nxt = idx_r + CW'(1);
            rd_ok_nxt = 1'b1;
          end
        end else begin
          // Group ended at idx-1: its last entry fills the gap.
          wr_en = 1'b1;
          wr_addr = gap_r[AW-1:0];
          wr_data = carry_r;
          gap_nxt = idx_r - CW'(1);
          if (!occ) del_done = 1'b1;
          else begin
            carry_nxt = rd_data;
            if (idx_r == DEPTH_C - CW'(1)) begin
              // The last slot starts a group of one; it is visited again
              // next cycle so that it moves into the new gap.
              rd_ok_nxt = 1'b1;
            end else begin
              idx_nxt = idx_r + CW'(1);
              rd_ok_nxt = 1'b1;
            end
          end
        end
      end
    end
    if (cmd.ins_final) begin
      wr_en = 1'b1;
      wr_addr = pos_r[AW-1:0];
      wr_data = {key_r, par_r, info_r};
    end
    if (cmd.del_final) begin
      wr_en = 1'b1;
      wr_addr = gap_r[AW-1:0];
    end
    // Verdict at the end of the scan.
    if (scan_done) begin
      info_out_nxt = 32'd0;
      unique case (op_r)
        OP_INSERT: begin
          if (key_r == 32'd0) status_nxt = ST_INVALID;
          else if (full_nxt) status_nxt = ST_FULL;
          else if (found_nxt) status_nxt = ST_DUPLICATE;
          else if (!par_ok_nxt) status_nxt = ST_NO_PARENT;
          else status_nxt = ST_OK;
        end
        OP_SEARCH: begin
          if (key_r != 32'd0 && found_nxt) begin
            status_nxt = ST_OK;
            info_out_nxt = finfo_nxt;
          end else status_nxt = ST_NOT_FOUND;
        end
        default: begin
          if (op_r == OP_DEL_LEAF && child_nxt) status_nxt = ST_HAS_CHILD;
          else if (key_r == 32'd0) status_nxt = ST_INVALID;
          else if (!found_nxt) status_nxt = ST_NOT_FOUND;
          else status_nxt = ST_OK;
        end
      endcase
      gap_nxt = hit_nxt;
      idx_nxt = hit_nxt;
      rd_ok_nxt = 1'b1;
    end
  end

  // Registers of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
    if (cmd.load) begin
      op_r <= in_op;
      key_r <= in_key;
      par_r <= in_parent_key;
      info_r <= in_info;
    end
    pos_r <= pos_nxt;
    hit_r <= hit_nxt;
    found_r <= found_nxt;
    child_r <= child_nxt;
    par_ok_r <= par_ok_nxt;
    full_r <= full_nxt;
    finfo_r <= finfo_nxt;
    carry_r <= carry_nxt;
    gap_r <= gap_nxt;
    status_r <= status_nxt;
    info_out_r <= info_out_nxt;
  end

  assign sts.scan_done = scan_done;
  assign sts.ins_done = ins_done;
  assign sts.del_done = del_done;
  assign sts.clr_done = cmd.clr_step && (idx_r == DEPTH_C - CW'(1));
  assign sts.verdict = status_r;
  assign sts.go_insert = (op_r == OP_INSERT) && (status_r == ST_OK);
  assign sts.go_delete = (op_r != OP_INSERT) && (op_r != OP_SEARCH) &&
                         (status_r == ST_OK);
  assign status = status_r;
  assign info_out = info_out_r;
endmodule

/* sv/pgkt_checker.sv */
`timescale 1ns / 1ps
`include "parent_grouped_key_table_top_assert.svh"
module pgkt_checker
  import pgkt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] info_out
);
  // One operation at a time: no input taken while a result waits.
  `PGKT_ASSERT_IMP(a_excl, out_valid, !in_ready)
  // A stalled result holds.
  `PGKT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status))
  // Info is only returned with an ok status.
  `PGKT_ASSERT_IMP(a_info, out_valid && status != ST_OK, info_out == 32'd0)
  // Status codes stay in range.
  `PGKT_ASSERT_IMP(a_range, out_valid, status <= ST_HAS_CHILD)
endmodule

bind parent_grouped_key_table_top pgkt_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .info_out(out_ch.info_out)
);

/* test/parent_grouped_key_table_top_tb.sv */
`timescale 1ns / 1ps
module parent_grouped_key_table_top_tb;
  import pgkt_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;

  // Expected result of one operation.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] info_out;
  } table_result_t;

  // Scoreboard: a software copy of the table and the results it predicts.
  class table_scoreboard;
    logic [31:0] tkey [DEPTH];
    logic [31:0] tpar [DEPTH];
    logic [31:0] tinf [DEPTH];
    logic [31:0] meta;
    table_result_t pending[$];
    int mismatches;

    function new();
      meta = '0;
      mismatches = 0;
      for (int i = 0; i < DEPTH; i++) begin
        tkey[i] = '0; tpar[i] = '0; tinf[i] = '0;
      end
    endfunction

    function int occupied();
      int n;
      n = 0;
      while (n < DEPTH && tkey[n] != 0) n++;
      return n;
    endfunction

    function logic [2:0] insert_entry(logic [31:0] k, logic [31:0] p, logic [31:0] v);
      int pos;
      bit par_ok;
      logic [31:0] hk, hp, hv, sk, sp, sv;
      pos = 0;
      par_ok = (p == 0) || (p == meta);
      if (k == 0) return ST_INVALID;
      if (tkey[DEPTH-1] != 0) return ST_FULL;
      for (int i = 0; i < DEPTH && tkey[i] != 0; i++) begin
        if (tkey[i] == k) return ST_DUPLICATE;
        if (tpar[i] <= p) pos = i + 1;
        if (tkey[i] == p) par_ok = 1;
      end
      if (!par_ok) return ST_NO_PARENT;
      // Each later group's head moves to the slot just past that group.
      hk = tkey[pos]; hp = tpar[pos]; hv = tinf[pos];
      for (int i = pos + 1; i < DEPTH; i++) begin
        if (!(tkey[i] != 0 && tpar[i] == hp)) begin
          sk = tkey[i]; sp = tpar[i]; sv = tinf[i];
          tkey[i] = hk; tpar[i] = hp; tinf[i] = hv;
          hk = sk; hp = sp; hv = sv;
        end
      end
      tkey[pos] = k; tpar[pos] = p; tinf[pos] = v;
      return ST_OK;
    endfunction

    function logic [2:0] remove_entry(logic [31:0] k);
      int gap, e;
      gap = DEPTH;
      if (k == 0) return ST_INVALID;
      for (int i = 0; i < DEPTH && tkey[i] != 0; i++)
        if (tkey[i] == k && gap == DEPTH) gap = i;
      if (gap >= DEPTH) return ST_NOT_FOUND;
      // The last entry of each later group drops into the gap.
      while (gap + 1 < DEPTH && tkey[gap+1] != 0) begin
        e = gap + 1;
        while (e + 1 < DEPTH && tkey[e+1] != 0 && tpar[e+1] == tpar[gap+1]) e++;
        tkey[gap] = tkey[e]; tpar[gap] = tpar[e]; tinf[gap] = tinf[e];
        gap = e;
      end
      tkey[gap] = '0; tpar[gap] = '0; tinf[gap] = '0;
      return ST_OK;
    endfunction

    // Note an accepted input beat and predict its result.
    function void note_input(logic [1:0] op, logic [31:0] k, logic [31:0] p,
                             logic [31:0] v);
      table_result_t r;
      bit child;
      r = '0;
      case (op)
        OP_INSERT: r.status = insert_entry(k, p, v);
        OP_DELETE: r.status = remove_entry(k);
        OP_SEARCH: begin
          r.status = ST_NOT_FOUND;
          if (k != 0)
            for (int i = 0; i < DEPTH && tkey[i] != 0; i++)
              if (tkey[i] == k && r.status != ST_OK) begin
                r.status = ST_OK;
                r.info_out = tinf[i];
              end
        end
        default: begin
          child = 0;
          for (int i = 0; i < DEPTH && tkey[i] != 0; i++)
            if (tpar[i] == k) child = 1;
          r.status = child ? ST_HAS_CHILD : remove_entry(k);
        end
      endcase
      pending.push_back(r);
    endfunction

    // Check one result beat against the oldest prediction.
    function void check_result(logic [2:0] st, logic [31:0] inf);
      table_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", st);
        return;
      end
      e = pending.pop_front();
      if (e.status !== st || e.info_out !== inf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected status %0d info %h, got status %0d info %h",
                   e.status, e.info_out, st, inf);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;
  int send_idle, recv_idle;
  int cycles = 0;
  table_scoreboard sb;
  logic [31:0] used_keys[$];

  pgkt_in_if in_ch ();
  pgkt_out_if out_ch ();

  parent_grouped_key_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.op, in_ch.key, in_ch.parent_key, in_ch.info);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.info_out);
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Send one beat, holding it until it is taken. The beat stays on the
  // wires after acceptance until the next call or a drain replaces it.
  task automatic send_beat(logic [1:0] op, logic [31:0] k, logic [31:0] p,
                           logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op; in_ch.key <= k; in_ch.parent_key <= p; in_ch.info <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_meta(logic [31:0] value);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.meta = value;
  endtask

  // A key mostly from those seen before, so operations find entries.
  function automatic logic [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(99) < 75)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    if ($urandom_range(9) == 0) return $urandom >> $urandom_range(31);
    return $urandom_range(200, 1);
  endfunction

  // Random items; inserts favoured while the table is small.
  task automatic random_items(int n);
    logic [1:0] op;
    logic [31:0] k, p;
    int fill;
    for (int i = 0; i < n; i++) begin
      fill = sb.occupied();
      op = ($urandom_range(99) < (fill < 40 ? 55 : 30)) ? OP_INSERT : 2'($urandom_range(3));
      k = pick_key();
      case ($urandom_range(3))
        0: p = 0;
        1: p = sb.meta;
        2: p = pick_key();
        default: p = $urandom;
      endcase
      if (op == OP_INSERT && k != 0) used_keys.push_back(k);
      if (used_keys.size() > 300) void'(used_keys.pop_front());
      send_beat(op, k, p, $urandom);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.op = OP_INSERT;
    in_ch.key = '0; in_ch.parent_key = '0; in_ch.info = '0;
    send_idle = 0; recv_idle = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: each operation, each refusal and the field extremes.
    send_beat(OP_SEARCH, 32'd0, 32'd0, 32'd0);
    send_beat(OP_DEL_LEAF, 32'd5, 32'd0, 32'd0);
    send_beat(OP_INSERT, 32'd0, 32'd0, 32'd1);
    send_beat(OP_DELETE, 32'd0, 32'd0, 32'd0);
    send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'd0, 32'd3);
    send_beat(OP_INSERT, 32'd7, 32'd99, 32'd3);
    send_beat(OP_INSERT, 32'd7, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_beat(OP_INSERT, 32'd8, 32'd0, 32'd4);
    send_beat(OP_DEL_LEAF, 32'd0, 32'd0, 32'd0);
    send_beat(OP_DEL_LEAF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_beat(OP_SEARCH, 32'd7, 32'd0, 32'd0);
    send_beat(OP_DELETE, 32'd123, 32'd0, 32'd0);
    send_beat(OP_DEL_LEAF, 32'd7, 32'd0, 32'd0);
    send_beat(OP_DELETE, 32'd8, 32'd0, 32'd0);
    write_meta(32'hFFFF_FFFE);
    send_beat(OP_INSERT, 32'd9, 32'hFFFF_FFFE, 32'd1);
    send_beat(OP_SEARCH, 32'd9, 32'd0, 32'd0);
    // Fill the table to the brim, then try once more.
    for (int i = 0; i < DEPTH; i++)
      send_beat(OP_INSERT, 32'd1000 + i, ($urandom_range(1) != 0) ? 32'd9 : 32'd0, i);
    send_beat(OP_INSERT, 32'd1000, 32'd0, 32'd0);
    send_beat(OP_DELETE, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_beat(OP_INSERT, 32'd5000, 32'd0, 32'd0);
    for (int i = 0; i < DEPTH; i++) send_beat(OP_DELETE, 32'd1000 + i, 32'd0, 32'd0);

    send_idle = 34; recv_idle = 47;
    write_meta(32'd0);
    random_items(400);
    // Hold off until every prediction has been met.
    drain();
    send_idle = 47; recv_idle = 34;
    write_meta(32'hFFFF_FFFF);
    random_items(400);
    send_idle = 0; recv_idle = 0;
    write_meta(32'd50);
    random_items(330);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
